FILE: hw/rtl/md5rch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5rch_pkg: shared constants and round helpers for the md5 coordinate hash
// Holds the initial chaining words, the padding words, the sine constant
// table, the rotate amounts and the per-round mixing functions.
// ----------------------------------------------------------------------------
package md5rch_pkg;

	localparam int unsigned NUM_ROUNDS = 64;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// fixed padding: word 4 carries the end marker, word 15 the bit length
	localparam logic [31:0] PAD_WORD4  = 32'h80000000;
	localparam logic [31:0] PAD_WORD15 = 32'd128;

	localparam logic [3:0] IDX_PAD4  = 4'd4;
	localparam logic [3:0] IDX_PAD15 = 4'd15;

	localparam logic [31:0] RND_K [NUM_ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts, indexed by quarter * 4 + (round mod 4)
	localparam logic [4:0] ROT_AMT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [1:0] {
		QTR_F = 2'd0,
		QTR_G = 2'd1,
		QTR_H = 2'd2,
		QTR_I = 2'd3
	} quarter_t;

	function automatic logic [31:0] mix_fn(input quarter_t q, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		unique case (q)
			QTR_F: f = (b & c) | (~b & d);
			QTR_G: f = (d & b) | (~d & c);
			QTR_H: f = b ^ c ^ d;
			QTR_I: f = c ^ (b | ~d);
			default: f = '0;
		endcase
		return f;
	endfunction

	// message word used by a round
	function automatic logic [3:0] msg_index(input int unsigned rnd);
		int unsigned g;
		unique case (rnd / 16)
			0: g = rnd;
			1: g = rnd * 5 + 1;
			2: g = rnd * 3 + 5;
			default: g = rnd * 7;
		endcase
		return 4'(g % 16);
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {v, v} << s;
		return dbl[63:32];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/md5_round_coordinate_hash_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_round_coordinate_hash_top: keyed coordinate hash on md5 rounds
// Fully pipelined, one md5 round per stage, one hash word per clock.
// ----------------------------------------------------------------------------
// usage
//   input: drive coord_x..coord_w and pulse start; a word is taken at every
//   rising edge with start high and busy low. busy is never raised, so a new
//   word may enter in every cycle.
//   key: seed_key_we with seed_key_wdata loads the key that is xored into all
//   four coordinates; change it only while no word is in flight.
//   result: done is high for exactly one cycle with hash_a..hash_d valid.
//   the receiver cannot stall; results must be taken when done is high.
//   stages: one register stage per md5 round lies between the accepting
//   edge and done.
//   throughput: one word per cycle through the 64 round stages, each doing
//   one mixing function, one add of a, constant and message word, a rotate
//   and the add of b.
//   reset: arst_n clears the key and all stage valid bits; payload registers
//   keep no reset and are ignored until their valid bit is set.
// ----------------------------------------------------------------------------
module md5_round_coordinate_hash_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [31:0] coord_z,
	input  wire logic [31:0] coord_w,
	input  wire logic        seed_key_we,
	input  wire logic [31:0] seed_key_wdata,
	output logic             done,
	output logic [31:0]      hash_a,
	output logic [31:0]      hash_b,
	output logic [31:0]      hash_c,
	output logic [31:0]      hash_d
);

	localparam int unsigned NR = md5rch_pkg::NUM_ROUNDS;

	logic [31:0] seed_key_q;

	// stage n holds the state after n rounds; stage 0 is the entry point
	logic        vld_s [NR+1];
	logic [31:0] a_s   [NR+1];
	logic [31:0] b_s   [NR+1];
	logic [31:0] c_s   [NR+1];
	logic [31:0] d_s   [NR+1];
	logic [31:0] m_s   [NR+1][4];

	// the pipeline never backs up
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_key_q <= '0;
		end else if (seed_key_we) begin
			seed_key_q <= seed_key_wdata;
		end
	end

	// entry: keyed message words and initial chaining words
	assign vld_s[0]  = start & ~busy;
	assign a_s[0]    = md5rch_pkg::INIT_A;
	assign b_s[0]    = md5rch_pkg::INIT_B;
	assign c_s[0]    = md5rch_pkg::INIT_C;
	assign d_s[0]    = md5rch_pkg::INIT_D;
	assign m_s[0][0] = coord_x ^ seed_key_q;
	assign m_s[0][1] = coord_y ^ seed_key_q;
	assign m_s[0][2] = coord_z ^ seed_key_q;
	assign m_s[0][3] = coord_w ^ seed_key_q;

	for (genvar r = 0; r < NR; r++) begin : g_round
		localparam md5rch_pkg::quarter_t QTR = md5rch_pkg::quarter_t'(r / 16);
		localparam logic [3:0] GI = md5rch_pkg::msg_index(r);
		localparam logic [31:0] KC = md5rch_pkg::RND_K[r];
		localparam logic [4:0] SH = md5rch_pkg::ROT_AMT[(r / 16) * 4 + (r % 4)];

		logic [31:0] msg_word;
		logic [31:0] fsum;
		logic [31:0] new_b;

		// only words 0..3 vary; 4 and 15 are padding, the rest zero
		always_comb begin
			if (GI < 4'd4) begin
				msg_word = m_s[r][GI[1:0]];
			end else if (GI == md5rch_pkg::IDX_PAD4) begin
				msg_word = md5rch_pkg::PAD_WORD4;
			end else if (GI == md5rch_pkg::IDX_PAD15) begin
				msg_word = md5rch_pkg::PAD_WORD15;
			end else begin
				msg_word = '0;
			end
		end

		assign fsum  = md5rch_pkg::mix_fn(QTR, b_s[r], c_s[r], d_s[r])
			+ a_s[r] + KC + msg_word;
		assign new_b = b_s[r] + md5rch_pkg::rotl(fsum, SH);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r+1] <= 1'b0;
			end else begin
				vld_s[r+1] <= vld_s[r];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[r]) begin
				a_s[r+1] <= d_s[r];
				b_s[r+1] <= new_b;
				c_s[r+1] <= b_s[r];
				d_s[r+1] <= c_s[r];
				m_s[r+1] <= m_s[r];
			end
		end
	end

	assign done   = vld_s[NR];
	assign hash_a = a_s[NR];
	assign hash_b = b_s[NR];
	assign hash_c = c_s[NR];
	assign hash_d = d_s[NR];

`ifndef ASSERT_OFF
	// every accepted word comes out at done after passing all round stages
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##64 done)
		else $error("accepted word did not finish after 64 stages");

	// no result without a matching accept
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 64))
		else $error("result without an accepted word");

	// halfway stage tracks the entry point
	a_mid_valid: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##32 vld_s[32])
		else $error("valid bit lost in the first half of the pipeline");
`endif

endmodule
`default_nettype wire
